[src/evdbs_pkg.sv]
// ----------------------------------------------------------------------------
// evdbs_pkg
// shared types and constants of the block deframer and byte swapper
// ----------------------------------------------------------------------------
package evdbs_pkg;

  localparam logic [31:0] MagicNative  = 32'hc0da0100;
  localparam logic [31:0] MagicForeign = 32'h0001dac0;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StEof     = 3'd1;
  localparam logic [2:0] StMagic   = 3'd2;
  localparam logic [2:0] StBlkLim  = 3'd3;
  localparam logic [2:0] StEvBlk   = 3'd4;
  localparam logic [2:0] StEvBig   = 3'd5;
  localparam logic [2:0] StTrunc   = 3'd6;
  localparam logic [2:0] StUnknown = 3'd7;

  localparam logic [1:0] RegSwapEn  = 2'd0;
  localparam logic [1:0] RegMaxEv   = 2'd1;
  localparam logic [1:0] RegMaxBlk  = 2'd2;

  localparam logic [2:0] KCopy   = 3'd0;
  localparam logic [2:0] K16     = 3'd1;
  localparam logic [2:0] K32     = 3'd2;
  localparam logic [2:0] K64     = 3'd3;
  localparam logic [2:0] KTagseg = 3'd4;
  localparam logic [2:0] KSeg    = 3'd5;
  localparam logic [2:0] KBank   = 3'd6;
  localparam logic [2:0] KBad    = 3'd7;

  // one result item
  typedef struct packed {
    logic [31:0] data_word;
    logic        word_valid;
    logic        last_of_event;
    logic [2:0]  status;
  } res_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [31:0] word;
    logic        walk;    // event word that goes through the structure walk
    logic        last;
    logic        start;   // first word of a walked event (top bank length)
    logic        emit;    // front produces a result on its own
    res_t        res;
  } fitem_t;

  function automatic logic [31:0] bsw(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [31:0] hsw(input logic [31:0] w);
    return {w[23:16], w[31:24], w[7:0], w[15:8]};
  endfunction

  function automatic logic [2:0] classify(input logic [7:0] t);
    logic [2:0] k;
    unique case (t)
      8'h08, 8'h09, 8'h0a: k = K64;
      8'h01, 8'h02, 8'h0b: k = K32;
      8'h04, 8'h05:        k = K16;
      8'h00, 8'h06, 8'h07: k = KCopy;
      8'h0c:               k = KTagseg;
      8'h0d, 8'h20:        k = KSeg;
      8'h0e, 8'h10:        k = KBank;
      default:             k = KBad;
    endcase
    return k;
  endfunction

endpackage

[src/evdbs_front.sv]
// ----------------------------------------------------------------------------
// evdbs_front
// header collection, block and event framing, classification of each word
// ----------------------------------------------------------------------------
module evdbs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_word,
  input  logic                  swap_enable,
  input  logic [23:0]           max_event_words,
  input  logic [23:0]           max_block_words,
  output logic                  q_wr,
  output evdbs_pkg::fitem_t     q_wdata,
  input  logic                  q_full
);

  typedef enum logic [3:0] {
    PH_HEAD  = 4'b0001,
    PH_START = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [31:0] held_r, held_nxt;
  logic        swap_on_r, swap_on_nxt;
  logic [23:0] blk_r, blk_nxt;
  logic [23:0] ev_r, ev_nxt;
  logic        walk_r, walk_nxt;   // event takes the walk

  logic        acc;
  logic [31:0] len, l;
  logic [32:0] elen;
  logic [23:0] ev_dec, blk_dec;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    phase_nxt   = phase_r;
    hcnt_nxt    = hcnt_r;
    held_nxt    = held_r;
    swap_on_nxt = swap_on_r;
    blk_nxt     = blk_r;
    ev_nxt      = ev_r;
    walk_nxt    = walk_r;
    q_wr        = 1'b0;
    q_wdata     = '0;
    q_wdata.word = in_word;
    len  = swap_on_r ? evdbs_pkg::bsw(held_r) : held_r;
    l    = swap_on_r ? evdbs_pkg::bsw(in_word) : in_word;
    elen = {1'b0, l} + 33'd1;
    ev_dec  = (ev_r != 24'd0) ? ev_r - 24'd1 : ev_r;
    blk_dec = (blk_r != 24'd0) ? blk_r - 24'd1 : blk_r;
    if (acc) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (hcnt_r == 3'd0) held_nxt = in_word;
          if (hcnt_r != 3'd7) begin
            hcnt_nxt = hcnt_r + 3'd1;
          end else begin
            hcnt_nxt = 3'd0;
            len = (in_word == evdbs_pkg::MagicForeign) ? evdbs_pkg::bsw(held_r) : held_r;
            q_wr = 1'b1;
            q_wdata.emit = 1'b1;
            if (in_word != evdbs_pkg::MagicNative && in_word != evdbs_pkg::MagicForeign) begin
              q_wdata.res.status = evdbs_pkg::StMagic;
            end else begin
              swap_on_nxt = (in_word == evdbs_pkg::MagicForeign);
              if (len == 32'd8) begin
                q_wdata.res.status = evdbs_pkg::StEof;
              end else if (len < 32'd8 || len > {8'd0, max_block_words}) begin
                q_wdata.res.status = evdbs_pkg::StBlkLim;
              end else begin
                q_wr = 1'b0;
                blk_nxt = len[23:0] - 24'd8;
                phase_nxt = PH_START;
              end
            end
          end
        end
        PH_START: begin
          hcnt_nxt = 3'd0;
          if (blk_r == 24'd0) begin
            phase_nxt = PH_HEAD;
          end else if (elen > {9'd0, blk_r}) begin
            blk_nxt = blk_r - 24'd1;
            ev_nxt  = blk_r - 24'd1;
            phase_nxt = (blk_r != 24'd1) ? PH_SKIP : PH_HEAD;
            q_wr = 1'b1;
            q_wdata.emit = 1'b1;
            q_wdata.res.status = evdbs_pkg::StEvBlk;
          end else begin
            blk_nxt = blk_r - 24'd1;
            ev_nxt  = l[23:0];
            q_wr = 1'b1;
            if (elen > {9'd0, max_event_words}) begin
              phase_nxt = (l != 32'd0) ? PH_SKIP
                        : ((blk_r != 24'd1) ? PH_START : PH_HEAD);
              q_wdata.emit = 1'b1;
              q_wdata.res.status = evdbs_pkg::StEvBig;
            end else begin
              phase_nxt = (l != 32'd0) ? PH_BODY
                        : ((blk_r != 24'd1) ? PH_START : PH_HEAD);
              walk_nxt = swap_on_r && swap_enable;
              q_wdata.last = (l == 32'd0);
              if (swap_on_r && swap_enable) begin
                q_wdata.walk  = 1'b1;
                q_wdata.start = 1'b1;
              end else begin
                q_wdata.emit = 1'b1;
                q_wdata.res  = '{in_word, 1'b1, (l == 32'd0), evdbs_pkg::StOk};
              end
            end
          end
        end
        PH_SKIP: begin
          ev_nxt  = ev_dec;
          blk_nxt = blk_dec;
          if (ev_dec == 24'd0) phase_nxt = (blk_dec != 24'd0) ? PH_START : PH_HEAD;
        end
        PH_BODY: begin
          ev_nxt  = ev_dec;
          blk_nxt = blk_dec;
          q_wr = 1'b1;
          q_wdata.last = (ev_dec == 24'd0);
          q_wdata.walk = walk_r;
          if (!walk_r) begin
            q_wdata.emit = 1'b1;
            q_wdata.res  = '{in_word, 1'b1, (ev_dec == 24'd0), evdbs_pkg::StOk};
          end
          if (ev_dec == 24'd0) phase_nxt = (blk_dec != 24'd0) ? PH_START : PH_HEAD;
        end
        default: phase_nxt = PH_HEAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEAD;
      hcnt_r    <= 3'd0;
      held_r    <= '0;
      swap_on_r <= 1'b0;
      blk_r     <= '0;
      ev_r      <= '0;
      walk_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hcnt_r    <= hcnt_nxt;
      held_r    <= held_nxt;
      swap_on_r <= swap_on_nxt;
      blk_r     <= blk_nxt;
      ev_r      <= ev_nxt;
      walk_r    <= walk_nxt;
    end
  end

endmodule

[src/evdbs_queue.sv]
// ----------------------------------------------------------------------------
// evdbs_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module evdbs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  evdbs_pkg::fitem_t wdata,
  output logic              full,
  input  logic              rd,
  output evdbs_pkg::fitem_t rdata,
  output logic              empty
);

  evdbs_pkg::fitem_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr} - {2'd0, rd};
    end
  end

endmodule

[src/evdbs_back.sv]
// ----------------------------------------------------------------------------
// evdbs_back
// nested structure walk, payload swapping and result output register
// ----------------------------------------------------------------------------
module evdbs_back #(
  parameter int NEST_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  evdbs_pkg::fitem_t q_rdata,
  output logic              q_rd,
  output logic              out_valid,
  input  logic              out_ready,
  output evdbs_pkg::res_t   out_res
);

  localparam int LW = $clog2(NEST_DEPTH + 1);
  localparam int IW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  logic [23:0] nwl_r [NEST_DEPTH];
  logic [2:0]  nkd_r [NEST_DEPTH];
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [2:0]  lk_r, lk_nxt;
  logic [23:0] lwl_r, lwl_nxt;
  logic [31:0] pair_r;
  logic        failed_r, failed_nxt, hdr_r, hdr_nxt, held_r, held_nxt;

  // two-slot output: slot 0 shown, slot 1 second result of a pair
  evdbs_pkg::res_t o0_r, o1_r;
  logic        v0_r, v1_r;

  logic        go, wr_stk, set_pair;
  logic [IW-1:0] wr_idx, top;
  logic [23:0] wr_val;
  logic [2:0]  wr_kind;
  logic [1:0]  nres;
  evdbs_pkg::res_t r0, r1;
  logic [31:0] w, s;
  logic        last;
  logic [2:0]  k;
  logic [23:0] rem, rem_new;
  logic [15:0] slen;
  logic [LW-1:0] lvl_push;

  assign out_valid = v0_r;
  assign out_res   = o0_r;
  // take an item when the output has space for two results
  assign go   = !q_empty && (!v0_r || (out_ready && !v1_r));
  assign q_rd = go;
  assign top  = IW'(lvl_r - LW'(1));

  always_comb begin
    lvl_nxt = lvl_r; lk_nxt = lk_r; lwl_nxt = lwl_r;
    failed_nxt = failed_r; hdr_nxt = hdr_r; held_nxt = held_r;
    wr_stk = 1'b0; wr_idx = '0; wr_val = '0; wr_kind = evdbs_pkg::KCopy;
    set_pair = 1'b0; nres = 2'd0; r0 = '0; r1 = '0;
    w = q_rdata.word; s = evdbs_pkg::bsw(w); last = q_rdata.last;
    k = evdbs_pkg::classify(s[15:8]);
    rem = nwl_r[top]; rem_new = rem; slen = s[15:0];
    lvl_push = lvl_r + LW'(1);
    if (go) begin
      nres = 2'd1;
      if (q_rdata.emit) begin
        r0 = q_rdata.res;
        if (q_rdata.res.word_valid) failed_nxt = 1'b1;
      end else if (q_rdata.start) begin
        lvl_nxt = '0; held_nxt = 1'b0;
        if (s == 32'd0) begin
          failed_nxt = 1'b1; hdr_nxt = 1'b0; lwl_nxt = '0;
          r0 = '{w, 1'b1, last, evdbs_pkg::StTrunc};
        end else begin
          failed_nxt = 1'b0; hdr_nxt = 1'b1; lwl_nxt = s[23:0] - 24'd1;
          r0 = '{s, 1'b1, last, evdbs_pkg::StOk};
        end
      end else if (failed_r) begin
        r0 = '{w, 1'b1, last, evdbs_pkg::StOk};
      end else if (hdr_r) begin
        hdr_nxt = 1'b0;
        r0 = '{s, 1'b1, last, evdbs_pkg::StOk};
        if (k == evdbs_pkg::KBad) begin
          failed_nxt = 1'b1; r0 = '{w, 1'b1, last, evdbs_pkg::StUnknown};
        end else if (k >= evdbs_pkg::KTagseg) begin
          if (lvl_r >= LW'(NEST_DEPTH)) begin
            failed_nxt = 1'b1; r0 = '{w, 1'b1, last, evdbs_pkg::StTrunc};
          end else begin
            wr_stk = 1'b1; wr_idx = IW'(lvl_r); wr_val = lwl_r; wr_kind = k;
            lwl_nxt = '0;
            // a freshly pushed empty level pops at once; lower ones were popped
            lvl_nxt = (lwl_r == 24'd0) ? lvl_r : lvl_push;
          end
        end else begin
          lk_nxt = k; held_nxt = 1'b0;
        end
      end else if (lwl_r != 24'd0) begin
        lwl_nxt = lwl_r - 24'd1;
        r0 = '{w, 1'b1, last, evdbs_pkg::StOk};
        if (lk_r == evdbs_pkg::K64) begin
          if (held_r) begin
            held_nxt = 1'b0; nres = 2'd2;
            r0 = '{s, 1'b1, 1'b0, evdbs_pkg::StOk};
            r1 = '{evdbs_pkg::bsw(pair_r), 1'b1, last, evdbs_pkg::StOk};
          end else if (lwl_r != 24'd1) begin
            set_pair = 1'b1; held_nxt = 1'b1; nres = 2'd0;
          end
        end else if (lk_r == evdbs_pkg::K32) begin
          r0.data_word = s;
        end else if (lk_r == evdbs_pkg::K16) begin
          r0.data_word = evdbs_pkg::hsw(w);
        end
      end else if (lvl_r != '0) begin
        r0 = '{s, 1'b1, last, evdbs_pkg::StOk};
        if (nkd_r[top] == evdbs_pkg::KBank) begin
          if (rem < 24'd2 || s == 32'd0 || ({1'b0, s} + 33'd1) > {9'd0, rem}) begin
            failed_nxt = 1'b1; r0 = '{w, 1'b1, last, evdbs_pkg::StTrunc};
          end else begin
            rem_new = rem - (s[23:0] + 24'd1);
            lwl_nxt = s[23:0] - 24'd1; hdr_nxt = 1'b1;
          end
        end else begin
          if ({8'd0, slen} + 25'd1 > {1'b0, rem}) begin
            failed_nxt = 1'b1; r0 = '{w, 1'b1, last, evdbs_pkg::StTrunc};
          end else begin
            rem_new = rem - ({8'd0, slen} + 24'd1);
            k = (nkd_r[top] == evdbs_pkg::KSeg) ? evdbs_pkg::classify({2'd0, s[21:16]})
                                                : evdbs_pkg::classify({4'd0, s[19:16]});
            lk_nxt = (k > evdbs_pkg::K64) ? evdbs_pkg::KCopy : k;
            lwl_nxt = {8'd0, slen}; held_nxt = 1'b0;
          end
        end
        if (!failed_nxt) begin
          wr_stk = 1'b1; wr_idx = top; wr_val = rem_new; wr_kind = nkd_r[top];
          // levels below the top are never empty, so one pop suffices
          if (rem_new == 24'd0) lvl_nxt = lvl_r - LW'(1);
        end
      end else begin
        r0 = '{w, 1'b1, last, evdbs_pkg::StOk};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_stk) begin
      nwl_r[wr_idx] <= wr_val;
      nkd_r[wr_idx] <= wr_kind;
    end
    if (set_pair) pair_r <= w;
    if (go && nres != 2'd0) begin
      o0_r <= r0;
      o1_r <= r1;
    end else if (out_ready && v0_r) begin
      o0_r <= o1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0; lk_r <= evdbs_pkg::KCopy; lwl_r <= '0;
      failed_r <= 1'b0; hdr_r <= 1'b0; held_r <= 1'b0;
      v0_r <= 1'b0; v1_r <= 1'b0;
    end else begin
      lvl_r <= lvl_nxt; lk_r <= lk_nxt; lwl_r <= lwl_nxt;
      failed_r <= failed_nxt; hdr_r <= hdr_nxt; held_r <= held_nxt;
      if (go && nres != 2'd0) begin
        v0_r <= 1'b1;
        v1_r <= (nres == 2'd2);
      end else if (out_ready && v0_r) begin
        v0_r <= v1_r;
        v1_r <= 1'b0;
      end
    end
  end

endmodule

[src/evio_block_deframer_byte_swapper_unit.sv]
// ----------------------------------------------------------------------------
// evio_block_deframer_byte_swapper_unit
// block deframer and event byte swapper for a 32-bit word stream
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | in_word
//   out_    | output    | out_valid / out_ready  | data_word, word_valid,
//           |           |                        | last_of_event, status
//   cfg_    | input     | apb psel/penable/pwrite| swap_enable, max_event_words,
//           |           |                        | max_block_words
//
// one word is accepted per cycle while the queue is not full; the front is
// combinational and writes the queue at the accepting edge, the back loads
// the output register from the queue, so a result is registered in the queue
// and then in the output register; a 64-bit pair gives two results from one word
// reset is synchronous, active low; no clearing pass
// in_ready drops only when the four-entry queue is full
module evio_block_deframer_byte_swapper_unit #(
  parameter int NEST_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data_word,
  output logic        out_word_valid,
  output logic        out_last_of_event,
  output logic [2:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic        swap_en_r;
  logic [23:0] max_ev_r, max_blk_r;
  logic [1:0]  reg_idx;

  // queue between front and back
  logic              q_wr, q_full, q_rd, q_empty;
  evdbs_pkg::fitem_t q_wdata, q_rdata;
  evdbs_pkg::res_t   res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_comb begin
    unique case (reg_idx)
      evdbs_pkg::RegSwapEn: prdata = {31'd0, swap_en_r};
      evdbs_pkg::RegMaxEv:  prdata = {8'd0, max_ev_r};
      evdbs_pkg::RegMaxBlk: prdata = {8'd0, max_blk_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_en_r <= 1'b1;
      max_ev_r  <= 24'd16777215;
      max_blk_r <= 24'd5000000;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      // writes off the register list are ignored
      unique case (reg_idx)
        evdbs_pkg::RegSwapEn: swap_en_r <= pwdata[0];
        evdbs_pkg::RegMaxEv:  max_ev_r  <= pwdata[23:0];
        evdbs_pkg::RegMaxBlk: max_blk_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  evdbs_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .swap_enable(swap_en_r), .max_event_words(max_ev_r), .max_block_words(max_blk_r),
    .q_wr, .q_wdata, .q_full
  );

  evdbs_queue u_queue (
    .clk, .rst_n, .wr(q_wr), .wdata(q_wdata), .full(q_full),
    .rd(q_rd), .rdata(q_rdata), .empty(q_empty)
  );

  evdbs_back #(.NEST_DEPTH(NEST_DEPTH)) u_back (
    .clk, .rst_n, .q_empty, .q_rdata, .q_rd,
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_data_word     = res.data_word;
  assign out_word_valid    = res.word_valid;
  assign out_last_of_event = res.last_of_event;
  assign out_status        = res.status;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// random and directed block streams for the deframer and byte swapper, with
// an in-bench prediction of every result item checked in order
// ----------------------------------------------------------------------------
module testbench;

  localparam int NestDepth = 8;
  localparam int DrainCycles = 16;   // covers front, queue, output register
  localparam int StallLimit = 4000;
  localparam int WordTarget = 900;

  typedef enum logic [3:0] {
    PhHead  = 4'b0001,
    PhStart = 4'b0010,
    PhBody  = 4'b0100,
    PhSkip  = 4'b1000
  } rd_phase_t;
  typedef enum logic [1:0] { OpWord, OpCfg, OpSync } op_kind_t;

  typedef struct {
    op_kind_t    kind;
    logic [3:0]  addr;
    logic [31:0] data;
  } op_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_data_word;
  logic        out_word_valid;
  logic        out_last_of_event;
  logic [2:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  evio_block_deframer_byte_swapper_unit #(.NEST_DEPTH(NestDepth)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_data_word(out_data_word), .out_word_valid(out_word_valid),
    .out_last_of_event(out_last_of_event), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor state: shadow registers and the deframer's own state
  // --------------------------------------------------------------------------
  logic        sh_swap_en = 1'b1;
  logic [23:0] sh_max_ev = 24'hFFFFFF;
  logic [23:0] sh_max_blk = 24'd5000000;

  rd_phase_t   rd_phase = PhHead;
  int unsigned hdr_cnt = 0;
  logic [31:0] held_len = '0;
  logic        swap_on = 1'b0;
  int unsigned blk_left = 0;
  int unsigned ev_left = 0;
  int unsigned nest_left [NestDepth];
  logic [2:0]  nest_kind [NestDepth];
  int unsigned nest_lvl = 0;
  logic [2:0]  leaf_kind = evdbs_pkg::KCopy;
  int unsigned leaf_left = 0;
  logic [31:0] pair_word = '0;
  logic        ev_failed = 1'b0;
  logic        hdr_pend = 1'b0;
  logic        pair_held = 1'b0;

  evdbs_pkg::res_t pending_results[$];

  function automatic logic [31:0] rev32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [31:0] rev16x2(input logic [31:0] w);
    return {w[23:16], w[31:24], w[7:0], w[15:8]};
  endfunction

  // content type code to payload kind
  function automatic logic [2:0] kind_of(input logic [7:0] t);
    case (t)
      8'h08, 8'h09, 8'h0a: return evdbs_pkg::K64;
      8'h01, 8'h02, 8'h0b: return evdbs_pkg::K32;
      8'h04, 8'h05:        return evdbs_pkg::K16;
      8'h00, 8'h06, 8'h07: return evdbs_pkg::KCopy;
      8'h0c:               return evdbs_pkg::KTagseg;
      8'h0d, 8'h20:        return evdbs_pkg::KSeg;
      8'h0e, 8'h10:        return evdbs_pkg::KBank;
      default:             return evdbs_pkg::KBad;
    endcase
  endfunction

  function automatic void note(input logic [31:0] d, input logic v, input logic last,
                               input logic [2:0] st);
    evdbs_pkg::res_t r;
    r.data_word = d;
    r.word_valid = v;
    r.last_of_event = last;
    r.status = st;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void flag_fault(input logic [31:0] w, input logic last,
                                     input logic [2:0] st);
    ev_failed = 1'b1;
    note(w, 1'b1, last, st);
  endfunction

  // free container levels whose last child has begun
  function automatic void pop_empty();
    while (nest_lvl > 0 && nest_left[nest_lvl - 1] == 0) nest_lvl--;
  endfunction

  function automatic void event_done();
    rd_phase = (blk_left != 0) ? PhStart : PhHead;
    hdr_cnt = 0;
  endfunction

  // one word of a swapped event walked through the bank structure
  function automatic void walk_word(input logic [31:0] w, input logic last);
    logic [31:0] s;
    logic [2:0]  k;
    int unsigned rem;
    int unsigned len;
    int unsigned top;
    s = rev32(w);
    if (hdr_pend) begin
      k = kind_of(s[15:8]);
      hdr_pend = 1'b0;
      if (k == evdbs_pkg::KBad) begin
        flag_fault(w, last, evdbs_pkg::StUnknown);
        return;
      end
      if (k >= evdbs_pkg::KTagseg) begin
        if (nest_lvl >= NestDepth) begin
          flag_fault(w, last, evdbs_pkg::StTrunc);
          return;
        end
        nest_left[nest_lvl] = leaf_left;
        nest_kind[nest_lvl] = k;
        nest_lvl++;
        leaf_left = 0;
        pop_empty();
      end else begin
        leaf_kind = k;
        pair_held = 1'b0;
      end
      note(s, 1'b1, last, evdbs_pkg::StOk);
      return;
    end
    if (leaf_left > 0) begin
      leaf_left--;
      if (leaf_kind == evdbs_pkg::K64) begin
        // first half of a pair is held back, the pair leaves swapped
        if (pair_held) begin
          pair_held = 1'b0;
          note(s, 1'b1, 1'b0, evdbs_pkg::StOk);
          note(rev32(pair_word), 1'b1, last, evdbs_pkg::StOk);
          return;
        end
        if (leaf_left > 0) begin
          pair_word = w;
          pair_held = 1'b1;
          return;
        end
        note(w, 1'b1, last, evdbs_pkg::StOk);
      end else if (leaf_kind == evdbs_pkg::K32) begin
        note(s, 1'b1, last, evdbs_pkg::StOk);
      end else if (leaf_kind == evdbs_pkg::K16) begin
        note(rev16x2(w), 1'b1, last, evdbs_pkg::StOk);
      end else begin
        note(w, 1'b1, last, evdbs_pkg::StOk);
      end
      return;
    end
    if (nest_lvl > 0) begin
      top = nest_lvl - 1;
      rem = nest_left[top];
      if (nest_kind[top] == evdbs_pkg::KBank) begin
        if (rem < 2 || s < 1 || ({32'b0, s} + 64'd1) > {32'b0, rem}) begin
          flag_fault(w, last, evdbs_pkg::StTrunc);
          return;
        end
        nest_left[top] = rem - (s + 1);
        leaf_left = s - 1;
        hdr_pend = 1'b1;
      end else begin
        len = s[15:0];
        if (len + 1 > rem) begin
          flag_fault(w, last, evdbs_pkg::StTrunc);
          return;
        end
        nest_left[top] = rem - (len + 1);
        if (nest_kind[top] == evdbs_pkg::KSeg) k = kind_of({2'b0, s[21:16]});
        else k = kind_of({4'b0, s[19:16]});
        leaf_kind = (k > evdbs_pkg::K64) ? evdbs_pkg::KCopy : k;
        leaf_left = len;
        pair_held = 1'b0;
      end
      pop_empty();
      note(s, 1'b1, last, evdbs_pkg::StOk);
      return;
    end
    note(w, 1'b1, last, evdbs_pkg::StOk);
  endfunction

  // expected results caused by one accepted stream word
  function automatic void deframe_word(input logic [31:0] w);
    logic [31:0] l;
    logic [31:0] len;
    logic [63:0] elen;
    logic        last;
    if (rd_phase == PhHead) begin
      if (hdr_cnt == 0) held_len = w;
      if (hdr_cnt < 7) begin
        hdr_cnt++;
        return;
      end
      hdr_cnt = 0;
      if (w == evdbs_pkg::MagicNative) swap_on = 1'b0;
      else if (w == evdbs_pkg::MagicForeign) swap_on = 1'b1;
      else begin
        note('0, 1'b0, 1'b0, evdbs_pkg::StMagic);
        return;
      end
      len = swap_on ? rev32(held_len) : held_len;
      if (len == 8) begin
        note('0, 1'b0, 1'b0, evdbs_pkg::StEof);
        return;
      end
      if (len < 8 || len > {8'b0, sh_max_blk}) begin
        note('0, 1'b0, 1'b0, evdbs_pkg::StBlkLim);
        return;
      end
      blk_left = (len - 8) & 32'hFFFFFF;
      rd_phase = PhStart;
      return;
    end
    if (rd_phase == PhStart) begin
      l = swap_on ? rev32(w) : w;
      elen = {32'b0, l} + 64'd1;
      if (blk_left == 0) begin
        event_done();
        return;
      end
      if (elen > {32'b0, blk_left}) begin
        // event runs past its block: skip the rest of the block
        blk_left--;
        ev_left = blk_left;
        if (ev_left != 0) rd_phase = PhSkip;
        else event_done();
        note('0, 1'b0, 1'b0, evdbs_pkg::StEvBlk);
        return;
      end
      blk_left--;
      ev_left = l;
      if (elen > {40'b0, sh_max_ev}) begin
        if (ev_left != 0) rd_phase = PhSkip;
        else event_done();
        note('0, 1'b0, 1'b0, evdbs_pkg::StEvBig);
        return;
      end
      last = (ev_left == 0);
      if (last) event_done();
      else rd_phase = PhBody;
      nest_lvl = 0;
      hdr_pend = 1'b0;
      pair_held = 1'b0;
      leaf_left = 0;
      if (swap_on && sh_swap_en) begin
        if (l == 0) begin
          ev_failed = 1'b1;
          note(w, 1'b1, last, evdbs_pkg::StTrunc);
          return;
        end
        ev_failed = 1'b0;
        leaf_left = l - 1;
        hdr_pend = 1'b1;
        note(rev32(w), 1'b1, last, evdbs_pkg::StOk);
      end else begin
        ev_failed = 1'b1;
        note(w, 1'b1, last, evdbs_pkg::StOk);
      end
      return;
    end
    if (ev_left != 0) ev_left--;
    if (blk_left != 0) blk_left--;
    if (rd_phase == PhSkip) begin
      if (ev_left == 0) event_done();
      return;
    end
    last = (ev_left == 0);
    if (ev_failed) note(w, 1'b1, last, evdbs_pkg::StOk);
    else walk_word(w, last);
    if (last) event_done();
  endfunction

  // --------------------------------------------------------------------------
  // stream generation
  // --------------------------------------------------------------------------
  op_t         op_q[$];
  logic [31:0] bank_words[$];     // logical words of the event being built
  int          nest_cap = 3;
  bit          deep_mode = 1'b0;
  logic [23:0] gen_max_blk = 24'd5000000;
  int          word_total = 0;

  function automatic void add_word(input logic [31:0] w);
    op_t o;
    o.kind = OpWord;
    o.addr = '0;
    o.data = w;
    op_q.insert(op_q.size(), o);
    word_total++;
  endfunction

  function automatic void add_cfg(input logic [1:0] reg_idx, input logic [31:0] val);
    op_t o;
    o.kind = OpCfg;
    o.addr = {reg_idx, 2'b00};
    o.data = val;
    op_q.insert(op_q.size(), o);
    if (reg_idx == evdbs_pkg::RegMaxBlk) gen_max_blk = val[23:0];
  endfunction

  function automatic void add_sync();
    op_t o;
    o.kind = OpSync;
    o.addr = '0;
    o.data = '0;
    op_q.insert(op_q.size(), o);
  endfunction

  function automatic logic [7:0] leaf_type();
    case ($urandom_range(0, 10))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h02;
      3: return 8'h0b;
      4: return 8'h04;
      5: return 8'h05;
      6: return 8'h08;
      7: return 8'h09;
      8: return 8'h0a;
      9: return 8'h06;
      default: return 8'h07;
    endcase
  endfunction

  function automatic logic [7:0] pick_type(input int depth);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'h30;       // not a known content type
    if (depth < nest_cap && r < (deep_mode ? 75 : 30)) begin
      case ($urandom_range(0, 4))
        0: return 8'h0e;
        1: return 8'h10;
        2: return 8'h0d;
        3: return 8'h20;
        default: return 8'h0c;
      endcase
    end
    return leaf_type();
  endfunction

  // segment or tagsegment child with a short payload
  function automatic void gen_child(input bit is_seg);
    int          at;
    int          n;
    logic [7:0]  t;
    at = bank_words.size();
    bank_words.insert(bank_words.size(), '0);
    n = $urandom_range(0, 4);
    repeat (n) bank_words.insert(bank_words.size(), $urandom);
    t = ($urandom_range(0, 3) == 0) ? 8'($urandom) : leaf_type();
    if (is_seg) bank_words[at] = {8'($urandom), 2'b00, t[5:0], 16'(n)};
    else bank_words[at] = {12'($urandom), t[3:0], 16'(n)};
  endfunction

  function automatic void gen_bank(input int depth);
    int          at;
    logic [7:0]  t;
    at = bank_words.size();
    bank_words.insert(bank_words.size(), '0);
    t = pick_type(depth);
    bank_words.insert(bank_words.size(), {16'($urandom), t, 8'($urandom)});
    case (kind_of(t))
      evdbs_pkg::KBank:   repeat ($urandom_range(0, 3)) gen_bank(depth + 1);
      evdbs_pkg::KSeg:    repeat ($urandom_range(0, 3)) gen_child(1'b1);
      evdbs_pkg::KTagseg: repeat ($urandom_range(0, 3)) gen_child(1'b0);
      default: repeat ($urandom_range(0, 5)) bank_words.insert(bank_words.size(), $urandom);
    endcase
    bank_words[at] = 32'(bank_words.size() - at - 1);
  endfunction

  // fault: 0 none, 1 bad magic, 2 end of file, 3 short length, 4 over limit,
  // 5 event past block, 6 zero-length event up front
  function automatic void gen_block(input bit foreign, input int fault);
    logic [31:0] body[$];
    logic [31:0] len;
    int          idx;
    repeat ($urandom_range(1, 3)) begin
      bank_words.delete();
      deep_mode = ($urandom_range(0, 7) == 0);
      nest_cap = deep_mode ? NestDepth + 2 : 3;
      gen_bank(0);
      if ($urandom_range(0, 9) == 0) begin
        idx = $urandom_range(1, bank_words.size() - 1);
        bank_words[idx] = $urandom;
      end
      foreach (bank_words[i])
        body.insert(body.size(), foreign ? rev32(bank_words[i]) : bank_words[i]);
    end
    if (fault == 6) body.push_front('0);
    if (fault == 5) begin
      len = (foreign ? rev32(body[0]) : body[0]) + body.size() + $urandom_range(0, 40);
      body[0] = foreign ? rev32(len) : len;
    end
    len = 8 + body.size();
    case (fault)
      2: len = 8;
      3: len = $urandom_range(0, 7);
      4: len = {8'b0, gen_max_blk} + 1 + $urandom_range(0, 100);
      default: ;
    endcase
    add_word(foreign ? rev32(len) : len);
    repeat (6) add_word($urandom);
    if (fault == 1) add_word($urandom | 32'h1);
    else add_word(foreign ? evdbs_pkg::MagicForeign : evdbs_pkg::MagicNative);
    if (fault == 0 || fault >= 5) foreach (body[i]) add_word(body[i]);
  endfunction

  function automatic void build_stream();
    int phase_blocks;
    int fault;
    int r;
    // directed: each error and both byte orders under reset settings
    gen_block(1'b1, 0);
    gen_block(1'b0, 0);
    for (int f = 1; f <= 6; f++) gen_block(1'b1, f);
    add_sync();
    // swapping disabled, smallest event limit, smallest block limit
    add_cfg(evdbs_pkg::RegSwapEn, 32'd0);
    gen_block(1'b1, 0);
    add_cfg(evdbs_pkg::RegSwapEn, 32'd1);
    add_cfg(evdbs_pkg::RegMaxEv, 32'd1);
    gen_block(1'b1, 0);
    add_cfg(evdbs_pkg::RegMaxBlk, 32'd8);
    gen_block(1'b1, 2);
    gen_block(1'b1, 4);
    add_cfg(evdbs_pkg::RegMaxEv, 32'hFFFFFF);
    add_cfg(evdbs_pkg::RegMaxBlk, 32'hFFFFFF);
    gen_block(1'b1, 0);
    // random phases with new settings every few blocks
    phase_blocks = 0;
    while (word_total < WordTarget) begin
      if (phase_blocks == 0) begin
        add_cfg(evdbs_pkg::RegSwapEn, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
        r = $urandom_range(0, 5);
        add_cfg(evdbs_pkg::RegMaxEv,
                (r == 0) ? 32'd1 : (r < 3) ? $urandom_range(2, 20) : 32'hFFFFFF);
        r = $urandom_range(0, 9);
        add_cfg(evdbs_pkg::RegMaxBlk,
                (r == 0) ? 32'd8 : (r < 4) ? $urandom_range(300, 1000) :
                (r < 7) ? 32'd5000000 : 32'hFFFFFF);
        phase_blocks = $urandom_range(3, 8);
      end
      fault = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
      if (gen_max_blk < 24'd300) fault = $urandom_range(2, 4);
      gen_block($urandom_range(0, 3) != 0, fault);
      phase_blocks--;
      if ($urandom_range(0, 15) == 0) add_sync();
    end
  endfunction

  // gap lengths: mostly none or short, a few long, now and then a calm run
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(40, 120);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 185) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // --------------------------------------------------------------------------
  // driver: input words, register writes, pauses; all changes at falling edge
  // --------------------------------------------------------------------------
  bit in_taken = 1'b0;
  int in_gap = 0;
  int in_calm = 0;
  int out_gap = 0;
  int out_calm = 0;
  int quiet_cycles = 0;
  int apb_step = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (apb_step == 1) begin
        penable <= 1'b1;
        apb_step = 2;
      end else if (apb_step == 2) begin
        // write took place at the rising edge just gone
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apb_step = 0;
        void'(op_q.pop_front());
      end else if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (op_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (op_q[0].kind == OpWord) begin
          in_valid <= 1'b1;
          in_word <= op_q[0].data;
          void'(op_q.pop_front());
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
          // settings change and pauses wait for the block to go quiet
          if (!in_valid && pending_results.size() == 0 && quiet_cycles >= DrainCycles) begin
            if (op_q[0].kind == OpSync) begin
              void'(op_q.pop_front());
            end else begin
              psel <= 1'b1;
              penable <= 1'b0;
              pwrite <= 1'b1;
              paddr <= op_q[0].addr;
              pwdata <= op_q[0].data;
              apb_step = 1;
            end
          end
        end
      end
      // receiver stalls
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap(out_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: acceptance, predictor update, result check, watchdog
  // --------------------------------------------------------------------------
  int   mismatches = 0;
  int   stall_cycles = 0;
  evdbs_pkg::res_t seen;
  evdbs_pkg::res_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        deframe_word(in_word);
        in_taken = 1'b1;
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          evdbs_pkg::RegSwapEn: sh_swap_en = pwdata[0];
          evdbs_pkg::RegMaxEv:  sh_max_ev = pwdata[23:0];
          evdbs_pkg::RegMaxBlk: sh_max_blk = pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = '{out_data_word, out_word_valid, out_last_of_event, out_status};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: data %h valid %b last %b status %0d",
                     seen.data_word, seen.word_valid, seen.last_of_event, seen.status);
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp data %h valid %b last %b status %0d, got %h %b %b %0d",
                       want.data_word, want.word_valid, want.last_of_event, want.status,
                       seen.data_word, seen.word_valid, seen.last_of_event, seen.status);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence: build the stream, reset once, wait for the drain, report
  // --------------------------------------------------------------------------
  initial begin
    build_stream();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (op_q.size() != 0 || in_valid || apb_step != 0 || pending_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/evdbs_pkg.sv
src/evdbs_front.sv
src/evdbs_queue.sv
src/evdbs_back.sv
src/evio_block_deframer_byte_swapper_unit.sv
tb/testbench.sv
